// ===== rtl/core/lcar_pkg.sv =====
`default_nettype none

package lcar_pkg;

	// field widths fixed by the pin-side protocol
	localparam int RAW_W  = 24;
	localparam int NET_W  = 25;
	localparam int CFG_W  = 24;
	localparam int IDX_W  = 3;
	localparam int GAIN_W = 2;
	localparam int PULSE_W = 2;

	typedef logic [IDX_W-1:0]   cfg_idx_t;
	typedef logic [GAIN_W-1:0]  gain_t;
	typedef logic [PULSE_W-1:0] pulse_cnt_t;

	// register map
	localparam cfg_idx_t REG_ENABLE     = 3'd0;
	localparam cfg_idx_t REG_PWR_DN     = 3'd1;
	localparam cfg_idx_t REG_GAIN       = 3'd2;
	localparam cfg_idx_t REG_TARE       = 3'd3;
	localparam cfg_idx_t REG_THRESHOLD  = 3'd4;

	// gain selection codes
	localparam gain_t GAIN_128 = 2'd0;
	localparam gain_t GAIN_64  = 2'd1;
	localparam gain_t GAIN_32  = 2'd2;

	localparam logic [CFG_W-1:0] THRESHOLD_RST = 24'd10;

	// extra clock pulses after the data bits, chosen by gain code
	function automatic pulse_cnt_t pulses_for_gain(input gain_t gain);
		pulse_cnt_t n;
		case (gain)
			GAIN_64: n = 2'd3;
			GAIN_32: n = 2'd2;
			default: n = 2'd1;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/load_cell_adc_reader_unit.sv =====
// A result appears on the output register in the cycle after its tick request is taken.
// Throughput: one tick request per clock while out_ready is high; the single result register
//   accepts a new request in the same cycle the waiting result is taken, so there is no bubble.
// Reset (arst_n low, asynchronous): idle, no result pending, enable 0, power-down off,
//   gain 0, tare 0, threshold 10, raw/net counts 0, no sample seen.
`default_nettype none

module load_cell_adc_reader_unit #(
	parameter int DATA_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_wr_en,
	input  wire lcar_pkg::cfg_idx_t              cfg_index,
	input  wire logic [lcar_pkg::CFG_W-1:0]      cfg_data,
	// tick requests
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            dout_level,
	// tick results
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 sck_level,
	output logic                                 sample_valid,
	output logic signed [lcar_pkg::RAW_W-1:0]    raw_count,
	output logic signed [lcar_pkg::NET_W-1:0]    net_count,
	output logic                                 steady,
	output logic                                 has_data
);

	// bit counter must hold DATA_BITS itself
	localparam int CNT_W = $clog2(DATA_BITS + 1);
	// working width for sign-extended raw, tare and differences
	localparam int EXT_W = ((DATA_BITS > lcar_pkg::RAW_W) ? DATA_BITS : lcar_pkg::RAW_W) + 1;

	// Read sequencer. A read starts from IDLE straight into the first bit's
	// clock-high tick, so BIT_HIGH only covers bits two onwards.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BIT_HIGH,
		PH_BIT_SAMPLE,
		PH_PULSE_HIGH,
		PH_PULSE_LOW,
		PH_SLEEP
	} phase_t;

	// configuration registers
	logic                            enable_q;
	logic                            pwr_dn_q;
	lcar_pkg::gain_t                 gain_q;
	logic [lcar_pkg::CFG_W-1:0]      tare_q;
	logic [lcar_pkg::CFG_W-1:0]      threshold_q;

	// sequencer state
	phase_t                          phase_q, phase_d;
	logic [CNT_W-1:0]                bit_count_q, bit_count_d, bit_inc;
	lcar_pkg::pulse_cnt_t            pulse_count_q, pulse_count_d, pulse_inc;
	logic [DATA_BITS-1:0]            shift_q, shift_d;

	// sample state; these also form the result register
	logic [DATA_BITS-1:0]            prev_raw_q;
	logic [lcar_pkg::NET_W-1:0]      net_hold_q;
	logic                            stable_q;
	logic                            data_seen_q;
	logic                            sck_q;
	logic                            sample_valid_q;
	logic                            out_valid_q;

	logic                            sck_d;
	logic                            finish;
	logic                            in_acc;

	// sample arithmetic
	logic signed [EXT_W-1:0]         raw_ext, prev_ext, tare_ext, delta, net_full;
	logic [EXT_W-1:0]                mag, thr_ext;
	logic                            stable_d;

	// A new request is taken whenever the result slot is empty or being emptied.
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	assign bit_inc   = bit_count_q + 1'b1;
	assign pulse_inc = pulse_count_q + 1'b1;

	always_comb begin
		phase_d       = phase_q;
		bit_count_d   = bit_count_q;
		pulse_count_d = pulse_count_q;
		shift_d       = shift_q;
		sck_d         = 1'b0;
		finish        = 1'b0;
		if (!enable_q) begin
			// disabled: drop any read, clock low
			phase_d       = PH_IDLE;
			bit_count_d   = '0;
			pulse_count_d = '0;
		end else if (pwr_dn_q) begin
			// clock held high puts the converter to sleep
			phase_d       = PH_SLEEP;
			bit_count_d   = '0;
			pulse_count_d = '0;
			sck_d         = 1'b1;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					// data-out low means a conversion is ready
					if (!dout_level) begin
						bit_count_d   = '0;
						pulse_count_d = '0;
						sck_d         = 1'b1;
						phase_d       = PH_BIT_SAMPLE;
					end
				end
				PH_BIT_HIGH: begin
					sck_d   = 1'b1;
					phase_d = PH_BIT_SAMPLE;
				end
				PH_BIT_SAMPLE: begin
					// MSB first
					shift_d     = {shift_q[DATA_BITS-2:0], dout_level};
					bit_count_d = bit_inc;
					phase_d     = (bit_inc >= CNT_W'(DATA_BITS)) ? PH_PULSE_HIGH : PH_BIT_HIGH;
				end
				PH_PULSE_HIGH: begin
					sck_d   = 1'b1;
					phase_d = PH_PULSE_LOW;
				end
				PH_PULSE_LOW: begin
					// gain read on every pulse, so a change mid-read takes effect at once
					if (pulse_inc >= lcar_pkg::pulses_for_gain(gain_q)) begin
						finish        = 1'b1;
						phase_d       = PH_IDLE;
						bit_count_d   = '0;
						pulse_count_d = '0;
					end else begin
						pulse_count_d = pulse_inc;
						phase_d       = PH_PULSE_HIGH;
					end
				end
				PH_SLEEP: begin
					// wake-up tick: clock low, back to idle
					phase_d       = PH_IDLE;
					bit_count_d   = '0;
					pulse_count_d = '0;
				end
				default: begin
					phase_d       = PH_IDLE;
					bit_count_d   = '0;
					pulse_count_d = '0;
				end
			endcase
		end
	end

	// Completed sample: sign-extend, difference against the last sample,
	// absolute value, threshold compare; net formed in parallel.
	assign raw_ext  = {{(EXT_W-DATA_BITS){shift_q[DATA_BITS-1]}}, shift_q};
	assign prev_ext = {{(EXT_W-DATA_BITS){prev_raw_q[DATA_BITS-1]}}, prev_raw_q};
	assign tare_ext = {{(EXT_W-lcar_pkg::CFG_W){tare_q[lcar_pkg::CFG_W-1]}}, tare_q};
	assign thr_ext  = {{(EXT_W-lcar_pkg::CFG_W){1'b0}}, threshold_q};
	assign delta    = raw_ext - prev_ext;
	assign mag      = delta[EXT_W-1] ? EXT_W'(-delta) : EXT_W'(delta);
	assign stable_d = data_seen_q && (mag <= thr_ext);
	assign net_full = raw_ext - tare_ext;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			pwr_dn_q     <= 1'b0;
			gain_q       <= lcar_pkg::GAIN_128;
			tare_q       <= '0;
			threshold_q  <= lcar_pkg::THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lcar_pkg::REG_ENABLE:     enable_q     <= cfg_data[0];
				lcar_pkg::REG_PWR_DN:     pwr_dn_q     <= cfg_data[0];
				lcar_pkg::REG_GAIN:       gain_q       <= cfg_data[lcar_pkg::GAIN_W-1:0];
				lcar_pkg::REG_TARE:       tare_q       <= cfg_data;
				lcar_pkg::REG_THRESHOLD:  threshold_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and result register. State moves only on an accepted request,
	// which only happens when the previous result has gone, so the held
	// sample registers double as the output payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bit_count_q    <= '0;
			pulse_count_q  <= '0;
			prev_raw_q     <= '0;
			net_hold_q     <= '0;
			stable_q       <= 1'b0;
			data_seen_q    <= 1'b0;
			sck_q          <= 1'b0;
			sample_valid_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q        <= phase_d;
				bit_count_q    <= bit_count_d;
				pulse_count_q  <= pulse_count_d;
				sck_q          <= sck_d;
				sample_valid_q <= finish;
				out_valid_q    <= 1'b1;
				if (finish) begin
					prev_raw_q  <= shift_q;
					net_hold_q  <= net_full[lcar_pkg::NET_W-1:0];
					stable_q    <= stable_d;
					data_seen_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// shift register needs no reset: every read refills all bits
	always_ff @(posedge clk) begin
		if (in_acc) begin
			shift_q <= shift_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign sck_level    = sck_q;
	assign sample_valid = sample_valid_q;
	assign raw_count    = prev_ext[lcar_pkg::RAW_W-1:0];
	assign net_count    = net_hold_q;
	assign steady       = stable_q;
	assign has_data     = data_seen_q;

endmodule

`default_nettype wire

// ===== rtl/core/lcar_checker.sv =====
`default_nettype none

module lcar_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic                            sck_level,
	input wire logic                            sample_valid,
	input wire logic                            has_data
);

	// a waiting result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// every taken request yields a result next cycle
	a_req_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request gave no result");

	// a completed sample is flagged only on a clock-low tick
	a_done_sck_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_valid |-> !sck_level)
		else $error("sample completed with clock high");

	// sample seen flag is sticky and set with the first sample
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(has_data) || (out_valid && sample_valid) |-> has_data)
		else $error("has_data not set or lost");

endmodule

bind load_cell_adc_reader_unit lcar_checker u_lcar_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.sck_level    (sck_level),
	.sample_valid (sample_valid),
	.has_data     (has_data)
);

`default_nettype wire
